[rtl/mks_pkg.sv]
package mks_pkg;

  // Default sizes
  localparam int MaxSymbolsDef = 8;
  localparam int CountWidthDef = 16;

  // Field widths
  localparam int CmdW   = 2;
  localparam int PatW   = 8;
  localparam int PlenW  = 4;
  localparam int PhaseW = 3;
  localparam int RegW   = 16;
  localparam int RegIdxW = 3;

  // Command codes
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd0;
  localparam logic [CmdW-1:0] CMD_LETTER = 2'd1;
  localparam logic [CmdW-1:0] CMD_PAUSE  = 2'd2;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE       = 3'd0;
  localparam logic [PhaseW-1:0] PH_START      = 3'd1;
  localparam logic [PhaseW-1:0] PH_ON         = 3'd2;
  localparam logic [PhaseW-1:0] PH_SYM_GAP    = 3'd3;
  localparam logic [PhaseW-1:0] PH_LETTER_GAP = 3'd4;
  localparam logic [PhaseW-1:0] PH_WORD_GAP   = 3'd5;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_DOT        = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DASH       = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SYM_GAP    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LETTER_GAP = 3'd3;
  localparam logic [RegIdxW-1:0] REG_WORD_GAP   = 3'd4;

  // Register reset values
  localparam logic [RegW-1:0] DOT_RST        = 16'd1;
  localparam logic [RegW-1:0] DASH_RST       = 16'd3;
  localparam logic [RegW-1:0] SYM_GAP_RST    = 16'd1;
  localparam logic [RegW-1:0] LETTER_GAP_RST = 16'd3;
  localparam logic [RegW-1:0] WORD_GAP_RST   = 16'd7;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic             encode_mode;
    logic [PatW-1:0]  pattern_bits;
    logic [PlenW-1:0] pattern_length;
  } mks_item_t;

  typedef struct packed {
    logic              key_on;
    logic              busy_res;
    logic [PhaseW-1:0] phase_code;
  } mks_result_t;

  typedef struct packed {
    logic [RegW-1:0] dot_length;
    logic [RegW-1:0] dash_length;
    logic [RegW-1:0] symbol_gap_length;
    logic [RegW-1:0] letter_gap_length;
    logic [RegW-1:0] word_gap_length;
  } mks_cfg_t;

endpackage

[rtl/mks_if.sv]
interface mks_in_if;
  logic                       valid;
  logic                       ready;
  logic [mks_pkg::CmdW-1:0]   cmd;
  logic                       encode_mode;
  logic [mks_pkg::PatW-1:0]   pattern_bits;
  logic [mks_pkg::PlenW-1:0]  pattern_length;

  modport source (output valid, cmd, encode_mode, pattern_bits, pattern_length,
                  input ready);
  modport sink (input valid, cmd, encode_mode, pattern_bits, pattern_length,
                output ready);
endinterface

interface mks_out_if;
  logic                       valid;
  logic                       ready;
  logic                       key_on;
  logic                       busy_res;
  logic [mks_pkg::PhaseW-1:0] phase_code;

  modport source (output valid, key_on, busy_res, phase_code, input ready);
  modport sink (input valid, key_on, busy_res, phase_code, output ready);
endinterface

[rtl/morse_keying_sequencer_unit.sv]
// Flow: a word accepted at the input sits in the input register; the core takes it
//   and loads its result into the result register when the output can take it.
// Throughput: one word per cycle while the output is not stalled; a tick, a start
//   or a pause is each one word, handled by the state update between the registers.
// Reset (rst_ni low, asynchronous): idle phase, key off, counters cleared,
//   timing registers back to dot 1, dash 3, symbol gap 1, letter gap 3, word gap 7.
module morse_keying_sequencer_unit #(
  parameter int MAX_SYMBOLS = mks_pkg::MaxSymbolsDef,
  parameter int COUNT_WIDTH = mks_pkg::CountWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mks_in_if.sink                       in_chan,
  mks_out_if.source                    out_chan,
  input  logic                         cfg_we_i,
  input  logic [mks_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [mks_pkg::RegW-1:0]     cfg_data_i
);
  import mks_pkg::*;

  mks_cfg_t    cfg;
  mks_item_t   in_item;
  mks_item_t   held_item;
  mks_result_t result;
  logic        held_valid;
  logic        core_ready;

  assign in_item.cmd            = in_chan.cmd;
  assign in_item.encode_mode    = in_chan.encode_mode;
  assign in_item.pattern_bits   = in_chan.pattern_bits;
  assign in_item.pattern_length = in_chan.pattern_length;

  mks_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mks_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_chan.valid),
    .ready_o (in_chan.ready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .ready_i (core_ready),
    .item_o  (held_item)
  );

  mks_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (held_valid),
    .ready_o  (core_ready),
    .item_i   (held_item),
    .valid_o  (out_chan.valid),
    .ready_i  (out_chan.ready),
    .result_o (result)
  );

  assign out_chan.key_on     = result.key_on;
  assign out_chan.busy_res   = result.busy_res;
  assign out_chan.phase_code = result.phase_code;

endmodule

[rtl/mks_cfg_regs.sv]
module mks_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mks_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [mks_pkg::RegW-1:0]     cfg_data_i,
  output mks_pkg::mks_cfg_t            cfg_o
);
  import mks_pkg::*;

  mks_cfg_t cfg_q;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_length        <= DOT_RST;
      cfg_q.dash_length       <= DASH_RST;
      cfg_q.symbol_gap_length <= SYM_GAP_RST;
      cfg_q.letter_gap_length <= LETTER_GAP_RST;
      cfg_q.word_gap_length   <= WORD_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DOT:        cfg_q.dot_length        <= cfg_data_i;
        REG_DASH:       cfg_q.dash_length       <= cfg_data_i;
        REG_SYM_GAP:    cfg_q.symbol_gap_length <= cfg_data_i;
        REG_LETTER_GAP: cfg_q.letter_gap_length <= cfg_data_i;
        REG_WORD_GAP:   cfg_q.word_gap_length   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/mks_in_stage.sv]
module mks_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  mks_pkg::mks_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output mks_pkg::mks_item_t item_o
);
  import mks_pkg::*;

  logic      valid_q;
  mks_item_t item_q;

  // Take a new word whenever the held one leaves or none is held
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/mks_core.sv]
module mks_core #(
  parameter int MAX_SYMBOLS = mks_pkg::MaxSymbolsDef,
  parameter int COUNT_WIDTH = mks_pkg::CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mks_pkg::mks_cfg_t    cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  mks_pkg::mks_item_t   item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output mks_pkg::mks_result_t result_o
);
  import mks_pkg::*;

  localparam int SidxW = $clog2(MAX_SYMBOLS + 1);
  localparam int ExtW  = (COUNT_WIDTH > RegW) ? COUNT_WIDTH : RegW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};
  localparam logic [ExtW-1:0]        CntMaxExt = ExtW'(CntMax);

  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [SidxW-1:0]       sidx_q, sidx_d;
  logic [SidxW-1:0]       len_q, len_d;
  logic [PatW-1:0]        pat_q, pat_d;
  logic                   key_q, key_d;
  logic                   out_valid_q;
  mks_result_t            res_q;
  logic                   take;
  logic                   cnt_done;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   is_dash;
  logic [PatW-1:0]        pat_shift;
  logic [RegW-1:0]        on_len;
  logic [SidxW-1:0]       len_sat;

  // Saturate a register value into the counter range
  function automatic logic [COUNT_WIDTH-1:0] cnt_load(input logic [RegW-1:0] v);
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    cnt_load = (ext > CntMaxExt) ? CntMax : COUNT_WIDTH'(ext);
  endfunction

  assign ready_o = !out_valid_q || ready_i;
  assign take    = valid_i && ready_o;

  // Count one tick down; the phase ends at one or zero
  assign cnt_done = (cnt_q <= COUNT_WIDTH'(1));
  assign cnt_dec  = cnt_done ? '0 : (cnt_q - COUNT_WIDTH'(1));

  // Symbols past the pattern width shift out and key as dots
  assign pat_shift = pat_q >> sidx_q;
  assign is_dash   = pat_shift[0];
  assign on_len    = is_dash ? cfg_i.dash_length : cfg_i.dot_length;

  assign len_sat = (int'(item_i.pattern_length) > MAX_SYMBOLS) ?
                   SidxW'(MAX_SYMBOLS) : SidxW'(item_i.pattern_length);

  // Next state for the word held at the input register
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    sidx_d  = sidx_q;
    len_d   = len_q;
    pat_d   = pat_q;
    key_d   = key_q;
    if (take) begin
      case (item_i.cmd)
        CMD_LETTER: begin
          if (phase_q == PH_IDLE) begin
            pat_d   = item_i.pattern_bits;
            len_d   = len_sat;
            sidx_d  = '0;
            key_d   = 1'b0;
            phase_d = PH_START;
          end
        end
        CMD_PAUSE: begin
          if (phase_q == PH_IDLE) begin
            key_d   = 1'b0;
            cnt_d   = cnt_load(cfg_i.word_gap_length);
            phase_d = PH_WORD_GAP;
          end
        end
        CMD_TICK: begin
          if (item_i.encode_mode) begin
            case (phase_q)
              PH_START: begin
                if (sidx_q >= len_q) begin
                  key_d   = 1'b0;
                  cnt_d   = cnt_load(cfg_i.letter_gap_length);
                  phase_d = PH_LETTER_GAP;
                end else begin
                  key_d   = 1'b1;
                  cnt_d   = cnt_load(on_len);
                  phase_d = PH_ON;
                end
              end
              PH_ON: begin
                cnt_d = cnt_dec;
                if (cnt_done) begin
                  key_d   = 1'b0;
                  cnt_d   = cnt_load(cfg_i.symbol_gap_length);
                  phase_d = PH_SYM_GAP;
                end
              end
              PH_SYM_GAP: begin
                cnt_d = cnt_dec;
                if (cnt_done) begin
                  sidx_d  = sidx_q + SidxW'(1);
                  phase_d = PH_START;
                end
              end
              PH_LETTER_GAP, PH_WORD_GAP: begin
                cnt_d = cnt_dec;
                if (cnt_done) begin
                  phase_d = PH_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      sidx_q  <= '0;
      len_q   <= '0;
      pat_q   <= '0;
      key_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sidx_q  <= sidx_d;
      len_q   <= len_d;
      pat_q   <= pat_d;
      key_q   <= key_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.key_on     <= key_d;
      res_q.busy_res   <= (phase_d != PH_IDLE);
      res_q.phase_code <= phase_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = res_q;

  // The key is only driven while a symbol is on
  a_key_only_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q |-> (phase_q == PH_ON))
    else $error("key driven outside the on phase");

  // The symbol index never runs past the letter length
  a_sidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE && phase_q != PH_WORD_GAP) |-> (sidx_q <= len_q))
    else $error("symbol index beyond letter length");

  // A start while busy leaves the phase alone
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.cmd == CMD_LETTER && phase_q != PH_IDLE) |=>
    (phase_q == $past(phase_q)))
    else $error("start taken while busy");

  // A result is registered for every word taken
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q)
    else $error("word taken without result");

endmodule

[test/morse_keying_sequencer_unit_tb.sv]
`timescale 1ns / 100ps

module morse_keying_sequencer_unit_tb;
  import mks_pkg::*;

  // Command code the block has no use for
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned LoudMismatches = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [RegW-1:0]    cfg_data_i;

  mks_in_if  in_chan ();
  mks_out_if out_chan ();

  morse_keying_sequencer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Words waiting to go out, and key states still owed by the block
  mks_item_t   word_q[$];
  mks_result_t key_state_q[$];
  mks_item_t   held_word;
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_odds = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Keyer state as the testbench sees it
  mks_cfg_t                 timing = '{DOT_RST, DASH_RST, SYM_GAP_RST, LETTER_GAP_RST,
                                       WORD_GAP_RST};
  logic [PhaseW-1:0]        k_phase = PH_IDLE;
  logic [CountWidthDef-1:0] k_count = '0;
  logic [PlenW-1:0]         k_index = '0;
  logic [PatW-1:0]          k_pattern = '0;
  logic [PlenW-1:0]         k_length = '0;
  logic                     k_key = 1'b0;

  // Clamp a duration to what the tick counter holds
  function automatic logic [CountWidthDef-1:0] count_load(logic [RegW-1:0] v);
    if (longint'(v) > (longint'(1) << CountWidthDef) - 1) return '1;
    return CountWidthDef'(v);
  endfunction

  // Count one tick; true once the phase has run its time
  function automatic logic count_expired();
    if (k_count <= 1) begin
      k_count = '0;
      return 1'b1;
    end
    k_count = k_count - 1'b1;
    return 1'b0;
  endfunction

  // Advance the keyer by one word and report its state afterwards
  function automatic mks_result_t key_step(mks_item_t w);
    mks_result_t r;
    logic        dash;
    case (w.cmd)
      CMD_LETTER: begin
        if (k_phase == PH_IDLE) begin
          k_pattern = w.pattern_bits;
          k_length  = (w.pattern_length > MaxSymbolsDef) ? PlenW'(MaxSymbolsDef)
                                                         : w.pattern_length;
          k_index   = '0;
          k_key     = 1'b0;
          k_phase   = PH_START;
        end
      end
      CMD_PAUSE: begin
        if (k_phase == PH_IDLE) begin
          k_key   = 1'b0;
          k_count = count_load(timing.word_gap_length);
          k_phase = PH_WORD_GAP;
        end
      end
      CMD_TICK: begin
        if (w.encode_mode) begin
          case (k_phase)
            PH_START: begin
              if (k_index >= k_length) begin
                k_key   = 1'b0;
                k_count = count_load(timing.letter_gap_length);
                k_phase = PH_LETTER_GAP;
              end else begin
                // symbols past the pattern byte go out as dots
                dash    = (k_index < PatW) ? k_pattern[k_index] : 1'b0;
                k_key   = 1'b1;
                k_count = count_load(dash ? timing.dash_length : timing.dot_length);
                k_phase = PH_ON;
              end
            end
            PH_ON: begin
              if (count_expired()) begin
                k_key   = 1'b0;
                k_count = count_load(timing.symbol_gap_length);
                k_phase = PH_SYM_GAP;
              end
            end
            PH_SYM_GAP: begin
              if (count_expired()) begin
                k_index = k_index + 1'b1;
                k_phase = PH_START;
              end
            end
            PH_LETTER_GAP, PH_WORD_GAP: begin
              if (count_expired()) k_phase = PH_IDLE;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.key_on     = k_key;
    r.busy_res   = (k_phase != PH_IDLE);
    r.phase_code = k_phase;
    return r;
  endfunction

  // Ticks a phase lasts; zero behaves as one
  function automatic int unsigned span(logic [RegW-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic void push_word(logic [CmdW-1:0] c, logic e, logic [PatW-1:0] b,
                                    logic [PlenW-1:0] n);
    mks_item_t w;
    w.cmd            = c;
    w.encode_mode    = e;
    w.pattern_bits   = b;
    w.pattern_length = n;
    word_q.push_back(w);
    queued_total++;
  endfunction

  // A random stray word: idle tick, spare, or a start or pause, which moves an idle keyer
  function automatic void push_noise();
    logic [CmdW-1:0] c;
    logic            e;
    c = CmdW'($urandom_range(0, 3));
    e = (c == CMD_TICK) ? 1'b0 : 1'($urandom);
    push_word(c, e, PatW'($urandom), PlenW'($urandom));
  endfunction

  function automatic void push_tick();
    push_word(CMD_TICK, 1'b1, PatW'($urandom), PlenW'($urandom));
  endfunction

  // Queue a letter or pause, ticks to end it (at times more or fewer), or stray words
  function automatic void queue_sequence();
    int unsigned     pick;
    int unsigned     ticks;
    int unsigned     k;
    int unsigned     symbols;
    logic [PatW-1:0] bits;
    logic [PlenW-1:0] len;
    pick  = $urandom_range(0, 9);
    ticks = 0;
    if (pick < 6) begin
      bits = PatW'($urandom);
      len  = ($urandom_range(0, 7) == 0) ? PlenW'($urandom_range(9, 15))
                                         : PlenW'($urandom_range(0, 8));
      push_word(CMD_LETTER, 1'($urandom), bits, len);
      symbols = (len > MaxSymbolsDef) ? MaxSymbolsDef : len;
      ticks   = 1 + span(timing.letter_gap_length);
      for (k = 0; k < symbols; k++)
        ticks += 1 + span(bits[k] ? timing.dash_length : timing.dot_length)
                   + span(timing.symbol_gap_length);
    end else if (pick < 8) begin
      push_word(CMD_PAUSE, 1'($urandom), PatW'($urandom), PlenW'($urandom));
      ticks = span(timing.word_gap_length);
    end else begin
      for (k = $urandom_range(1, 6); k > 0; k--) push_noise();
    end
    if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks + 2);
    k = 0;
    while (k < ticks) begin
      if ($urandom_range(0, 11) == 0) begin
        push_noise();
      end else begin
        push_tick();
        k++;
      end
    end
  endfunction

  function automatic void run_random(int unsigned n);
    int unsigned goal;
    goal = queued_total + n;
    while (queued_total < goal) queue_sequence();
  endfunction

  // Wait until every word is in and every key state is back
  task automatic drain();
    while (accepted_total != queued_total || key_state_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [RegW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_timing(mks_cfg_t t);
    write_reg(REG_DOT, t.dot_length);
    write_reg(REG_DASH, t.dash_length);
    write_reg(REG_SYM_GAP, t.symbol_gap_length);
    write_reg(REG_LETTER_GAP, t.letter_gap_length);
    write_reg(REG_WORD_GAP, t.word_gap_length);
    timing = t;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reset and known levels on every input
  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = REG_DOT;
    cfg_data_i             = '0;
    in_chan.valid          = 1'b0;
    in_chan.cmd            = CMD_TICK;
    in_chan.encode_mode    = 1'b0;
    in_chan.pattern_bits   = '0;
    in_chan.pattern_length = '0;
    out_chan.ready         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Drive words from the queue, with bursts of idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
      k_phase  = PH_IDLE;
      k_count  = '0;
      k_index  = '0;
      k_pattern = '0;
      k_length = '0;
      k_key    = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        key_state_q.push_back(key_step(held_word));
        accepted_total++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          send_gap = $urandom_range(1, 8);
        if (send_gap != 0 || word_q.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_chan.valid <= 1'b0;
        end else begin
          held_word = word_q.pop_front();
          in_chan.valid          <= 1'b1;
          in_chan.cmd            <= held_word.cmd;
          in_chan.encode_mode    <= held_word.encode_mode;
          in_chan.pattern_bits   <= held_word.pattern_bits;
          in_chan.pattern_length <= held_word.pattern_length;
        end
      end
    end
  end

  // Check each key state word against the oldest one owed, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    mks_result_t due;
    if (!rst_ni) begin
      out_chan.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (key_state_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= LoudMismatches)
            $display("unexpected word: key %0b busy %0b phase %0d",
                     out_chan.key_on, out_chan.busy_res, out_chan.phase_code);
        end else begin
          due = key_state_q.pop_front();
          if (out_chan.key_on !== due.key_on || out_chan.busy_res !== due.busy_res ||
              out_chan.phase_code !== due.phase_code) begin
            mismatch_count++;
            if (mismatch_count <= LoudMismatches)
              $display("mismatch: expected key %0b busy %0b phase %0d, got %0b %0b %0d",
                       due.key_on, due.busy_res, due.phase_code,
                       out_chan.key_on, out_chan.busy_res, out_chan.phase_code);
          end
        end
      end
      if (recv_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        recv_gap = $urandom_range(1, 8);
      if (recv_gap != 0) begin
        recv_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("morse_keying_sequencer_unit_tb failed");
      $finish;
    end
  end

  initial begin
    mks_cfg_t    t;
    int unsigned k;
    idle_odds = 6;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Reset timing: idle tick, spare command, pause started without encode mode
    push_word(CMD_TICK, 1'b1, 8'h00, 4'h0);
    push_word(CMD_SPARE, 1'b1, 8'hFF, 4'hF);
    push_word(CMD_PAUSE, 1'b0, 8'h00, 4'h0);
    // start while busy, then a tick with encode mode off
    push_word(CMD_LETTER, 1'b1, 8'hFF, 4'h8);
    push_word(CMD_TICK, 1'b0, 8'hFF, 4'hF);
    for (k = 0; k < span(timing.word_gap_length); k++) push_word(CMD_TICK, 1'b1, 8'h00, 4'h0);
    // empty letter goes straight to the letter gap
    push_word(CMD_LETTER, 1'b0, 8'h00, 4'h0);
    for (k = 0; k < 1 + span(timing.letter_gap_length); k++)
      push_word(CMD_TICK, 1'b1, 8'hFF, 4'hF);
    // one dot, every pattern bit but the first set
    push_word(CMD_LETTER, 1'b1, 8'hFE, 4'h1);
    for (k = 0; k < 7; k++) push_word(CMD_TICK, 1'b1, 8'h00, 4'h0);
    drain();

    // Zero durations end on the first tick
    t = '0;
    load_timing(t);
    idle_odds = 4;
    run_random(290);
    drain();

    // Short random durations, heavy idling
    t.dot_length        = RegW'($urandom_range(1, 6));
    t.dash_length       = RegW'($urandom_range(1, 6));
    t.symbol_gap_length = RegW'($urandom_range(1, 6));
    t.letter_gap_length = RegW'($urandom_range(1, 6));
    t.word_gap_length   = RegW'($urandom_range(1, 6));
    load_timing(t);
    idle_odds = 3;
    run_random(290);
    drain();

    // Long durations: run one full word pause to the end
    t = '1;
    t.word_gap_length = 16'd250;
    load_timing(t);
    idle_odds = 0;
    push_word(CMD_PAUSE, 1'b1, 8'h00, 4'h0);
    push_word(CMD_LETTER, 1'b1, 8'hFF, 4'h8);
    for (k = 0; k < span(timing.word_gap_length); k++) push_tick();
    push_tick();
    drain();

    // Moderate durations, light idling
    t.dot_length        = RegW'($urandom_range(1, 4));
    t.dash_length       = RegW'($urandom_range(1, 4));
    t.symbol_gap_length = RegW'($urandom_range(1, 4));
    t.letter_gap_length = RegW'($urandom_range(1, 4));
    t.word_gap_length   = RegW'($urandom_range(1, 4));
    load_timing(t);
    idle_odds = 10;
    run_random(290);
    drain();

    // Shortest legal durations, no idling to the end
    t.dot_length        = 16'd1;
    t.dash_length       = 16'd1;
    t.symbol_gap_length = 16'd1;
    t.letter_gap_length = 16'd1;
    t.word_gap_length   = 16'd1;
    load_timing(t);
    idle_odds = 0;
    run_random(290);
    drain();

    // Let any stray word surface before judging
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && key_state_q.size() == 0) begin
      $display("morse_keying_sequencer_unit_tb passed");
    end else begin
      $display("morse_keying_sequencer_unit_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mks_pkg.sv
rtl/mks_if.sv
rtl/mks_cfg_regs.sv
rtl/mks_in_stage.sv
rtl/mks_core.sv
rtl/morse_keying_sequencer_unit.sv
test/morse_keying_sequencer_unit_tb.sv
